@@ hdl/icdf_pkg.sv @@
// Package with the shared types and constants of the inverse CDF energy sampler.
package icdf_pkg;

  // Field widths of the item payloads and the configuration register.
  localparam int ENERGY_W  = 32;
  localparam int CUM_W     = 33;
  localparam int SLOPE_W   = 40;
  localparam int FRAC_W    = 32;
  localparam int INDEX_W   = 10;
  localparam int COUNT_W   = 11;

  // One table entry as stored in memory: {energy, cumulative, slope}.
  localparam int ENTRY_W   = ENERGY_W + CUM_W + SLOPE_W;

  // The 33 x 40 product is built from two 33 x 20 partial products.
  localparam int SLOPE_LO_W = 20;
  localparam int PROD_W     = CUM_W + SLOPE_LO_W;
  localparam int FULL_W     = CUM_W + SLOPE_W;
  localparam int OFF_W      = FULL_W - FRAC_W;

  // Smallest number of table points that forms one bin.
  localparam int MIN_POINTS = 2;

  // Configuration port.
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam logic CFG_IDX_BIN_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] BIN_COUNT_RESET = COUNT_W'(2);

  // Item mode codes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP,
    ST_BOT,
    ST_STEP,
    ST_CAP,
    ST_MULA,
    ST_MULB,
    ST_SUM,
    ST_EMIT
  } ctrl_state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_TOP,
    OP_BOT,
    OP_STEP,
    OP_CAP,
    OP_MULA,
    OP_MULB,
    OP_SUM,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic cum_ge;
    logic bot_done;
    logic step_done;
  } dp_status_t;

endpackage

@@ hdl/icdf_if.sv @@
// Handshake interfaces for the input item channel and the result item channel.
interface icdf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [icdf_pkg::INDEX_W-1:0]  point_index;
  logic [icdf_pkg::ENERGY_W-1:0] point_energy;
  logic [icdf_pkg::CUM_W-1:0]    point_cumulative;
  logic [icdf_pkg::SLOPE_W-1:0]  point_slope;
  logic [icdf_pkg::FRAC_W-1:0]   random_fraction;

  modport source (
    output valid, mode, point_index, point_energy, point_cumulative, point_slope,
           random_fraction,
    input  ready
  );
  modport sink (
    input  valid, mode, point_index, point_energy, point_cumulative, point_slope,
           random_fraction,
    output ready
  );
endinterface

interface icdf_out_if;
  logic                         valid;
  logic                         ready;
  logic [icdf_pkg::ENERGY_W-1:0] sampled_energy;
  logic [icdf_pkg::INDEX_W-1:0]  bin_found;

  modport source (
    output valid, sampled_energy, bin_found,
    input  ready
  );
  modport sink (
    input  valid, sampled_energy, bin_found,
    output ready
  );
endinterface

@@ hdl/icdf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module icdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/icdf_ctrl.sv @@
// Controller state machine that sequences load, search, multiply and result steps.
module icdf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output icdf_pkg::dp_cmd_t    cmd,
  input  icdf_pkg::dp_status_t status
);

  icdf_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  slot_free;
  logic                  in_accept;

  assign slot_free = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      icdf_pkg::ST_IDLE: begin
        if (in_valid && status.is_sample) begin
          state_nxt = icdf_pkg::ST_TOP;
        end
      end
      icdf_pkg::ST_TOP: begin
        state_nxt = status.cum_ge ? icdf_pkg::ST_CAP : icdf_pkg::ST_BOT;
      end
      icdf_pkg::ST_BOT: begin
        state_nxt = status.bot_done ? icdf_pkg::ST_CAP : icdf_pkg::ST_STEP;
      end
      icdf_pkg::ST_STEP: begin
        if (status.step_done) begin
          state_nxt = icdf_pkg::ST_CAP;
        end
      end
      icdf_pkg::ST_CAP:  state_nxt = icdf_pkg::ST_MULA;
      icdf_pkg::ST_MULA: state_nxt = icdf_pkg::ST_MULB;
      icdf_pkg::ST_MULB: state_nxt = icdf_pkg::ST_SUM;
      icdf_pkg::ST_SUM:  state_nxt = icdf_pkg::ST_EMIT;
      icdf_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = icdf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = icdf_pkg::ST_IDLE;
    endcase
  end

  // Datapath command and handshake outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = icdf_pkg::OP_NONE;
    unique case (state_r)
      icdf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = status.is_sample ? icdf_pkg::OP_START : icdf_pkg::OP_LOAD;
        end
      end
      icdf_pkg::ST_TOP:  cmd.op = icdf_pkg::OP_TOP;
      icdf_pkg::ST_BOT:  cmd.op = icdf_pkg::OP_BOT;
      icdf_pkg::ST_STEP: cmd.op = icdf_pkg::OP_STEP;
      icdf_pkg::ST_CAP:  cmd.op = icdf_pkg::OP_CAP;
      icdf_pkg::ST_MULA: cmd.op = icdf_pkg::OP_MULA;
      icdf_pkg::ST_MULB: cmd.op = icdf_pkg::OP_MULB;
      icdf_pkg::ST_SUM:  cmd.op = icdf_pkg::OP_SUM;
      icdf_pkg::ST_EMIT: cmd.op = slot_free ? icdf_pkg::OP_EMIT : icdf_pkg::OP_NONE;
      default:           cmd.op = icdf_pkg::OP_NONE;
    endcase
  end

  // The result register is full from the emit step until the receiver takes the item.
  always_comb begin
    out_valid_nxt = (out_valid_r && !out_ready) ||
                    (state_r == icdf_pkg::ST_EMIT && slot_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icdf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A sample item always starts with the probe of the top table point.
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && status.is_sample |=> state_r == icdf_pkg::ST_TOP)
    else $error("sample item did not start the search");

  // The emit step fills the result register and frees the block.
  a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == icdf_pkg::ST_EMIT && slot_free |=>
      out_valid_r && state_r == icdf_pkg::ST_IDLE)
    else $error("emit step did not deliver a result");

  // A result appears only out of the emit step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == icdf_pkg::ST_EMIT)
    else $error("result appeared outside the emit step");

endmodule

@@ hdl/icdf_dpath.sv @@
// Datapath: table memory, binary search registers, split multiplier and saturation.
module icdf_dpath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  icdf_pkg::dp_cmd_t                 cmd,
  output icdf_pkg::dp_status_t              status,
  input  logic [icdf_pkg::COUNT_W-1:0]      bin_count,
  input  logic                              in_mode,
  input  logic [icdf_pkg::INDEX_W-1:0]      in_point_index,
  input  logic [icdf_pkg::ENERGY_W-1:0]     in_point_energy,
  input  logic [icdf_pkg::CUM_W-1:0]        in_point_cumulative,
  input  logic [icdf_pkg::SLOPE_W-1:0]      in_point_slope,
  input  logic [icdf_pkg::FRAC_W-1:0]       in_random_fraction,
  output logic [icdf_pkg::ENERGY_W-1:0]     out_sampled_energy,
  output logic [icdf_pkg::INDEX_W-1:0]      out_bin_found
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // Memory port signals.
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [icdf_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [icdf_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [icdf_pkg::ENERGY_W-1:0] rd_energy;
  logic [icdf_pkg::CUM_W-1:0]    rd_cum;
  logic [icdf_pkg::SLOPE_W-1:0]  rd_slope;

  // Search state.
  logic [icdf_pkg::FRAC_W-1:0]   u_r;
  logic [AW-1:0]                 lo_r;
  logic [AW-1:0]                 hi_r;
  logic [AW-1:0]                 mid_r;
  logic [AW-1:0]                 n_m1;
  logic                          cum_ge;
  logic [AW-1:0]                 bot_mid;
  logic                          bot_done;
  logic [AW-1:0]                 step_lo;
  logic [AW-1:0]                 step_hi;
  logic [AW-1:0]                 step_span;
  logic [AW-1:0]                 step_mid;
  logic                          step_done;

  // Interpolation state.
  logic                          neg_r;
  logic [icdf_pkg::CUM_W-1:0]    diff_r;
  logic [icdf_pkg::ENERGY_W-1:0] energy_r;
  logic [icdf_pkg::SLOPE_W-1:0]  slope_r;
  logic [icdf_pkg::PROD_W-1:0]   prod_lo_r;
  logic [icdf_pkg::PROD_W-1:0]   prod_hi_r;
  logic [icdf_pkg::FULL_W-1:0]   full_prod;
  logic [icdf_pkg::OFF_W-1:0]    off_r;
  logic [icdf_pkg::OFF_W:0]      sum_pos;
  logic [icdf_pkg::ENERGY_W-1:0] result;
  logic [icdf_pkg::ENERGY_W-1:0] out_energy_r;
  logic [icdf_pkg::INDEX_W-1:0]  out_bin_r;

  // Last point in use: bin_count clamped into the table, minus one.
  always_comb begin
    if (bin_count < icdf_pkg::COUNT_W'(icdf_pkg::MIN_POINTS)) begin
      n_m1 = AW'(1);
    end else if (32'(bin_count) >= 32'(TABLE_DEPTH)) begin
      n_m1 = AW'(TABLE_DEPTH - 1);
    end else begin
      n_m1 = AW'(bin_count - icdf_pkg::COUNT_W'(1));
    end
  end

  // Table memory holding one full point per entry.
  assign ram_we    = (cmd.op == icdf_pkg::OP_LOAD) &&
                     (32'(in_point_index) < 32'(TABLE_DEPTH));
  assign ram_waddr = AW'(in_point_index);
  assign ram_wdata = {in_point_energy, in_point_cumulative, in_point_slope};

  icdf_ram #(
    .WIDTH (icdf_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_energy = ram_rdata[icdf_pkg::ENTRY_W-1 -: icdf_pkg::ENERGY_W];
  assign rd_cum    = ram_rdata[icdf_pkg::SLOPE_W +: icdf_pkg::CUM_W];
  assign rd_slope  = ram_rdata[icdf_pkg::SLOPE_W-1:0];

  // Probe compare and the next search interval.
  always_comb begin
    cum_ge    = {1'b0, u_r} >= rd_cum;
    bot_mid   = hi_r >> 1;
    bot_done  = !cum_ge || (hi_r <= AW'(1));
    step_lo   = cum_ge ? mid_r : lo_r;
    step_hi   = cum_ge ? hi_r : mid_r;
    step_span = step_hi - step_lo;
    step_done = step_span <= AW'(1);
    step_mid  = step_lo + (step_span >> 1);
  end

  // Read address: the next probe, or the final bin once the search ends.
  always_comb begin
    unique case (cmd.op)
      icdf_pkg::OP_START: ram_raddr = n_m1;
      icdf_pkg::OP_TOP:   ram_raddr = cum_ge ? (hi_r - AW'(1)) : '0;
      icdf_pkg::OP_BOT:   ram_raddr = bot_done ? '0 : bot_mid;
      icdf_pkg::OP_STEP:  ram_raddr = step_done ? step_lo : step_mid;
      default:            ram_raddr = lo_r;
    endcase
  end

  // Wide sum of the two partial products, and the saturated energy.
  always_comb begin
    full_prod = icdf_pkg::FULL_W'(prod_lo_r) +
                (icdf_pkg::FULL_W'(prod_hi_r) << icdf_pkg::SLOPE_LO_W);
    sum_pos   = (icdf_pkg::OFF_W + 1)'(energy_r) + (icdf_pkg::OFF_W + 1)'(off_r);
    if (neg_r) begin
      if (off_r >= icdf_pkg::OFF_W'(energy_r)) begin
        result = '0;
      end else begin
        result = energy_r - icdf_pkg::ENERGY_W'(off_r);
      end
    end else if (sum_pos > (icdf_pkg::OFF_W + 1)'({icdf_pkg::ENERGY_W{1'b1}})) begin
      result = '1;
    end else begin
      result = sum_pos[icdf_pkg::ENERGY_W-1:0];
    end
  end

  // Search, capture, multiply and result registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      icdf_pkg::OP_START: begin
        u_r  <= in_random_fraction;
        lo_r <= '0;
        hi_r <= n_m1;
      end
      icdf_pkg::OP_TOP: begin
        if (cum_ge) begin
          lo_r <= hi_r - AW'(1);
        end
      end
      icdf_pkg::OP_BOT: begin
        mid_r <= bot_mid;
      end
      icdf_pkg::OP_STEP: begin
        lo_r  <= step_lo;
        hi_r  <= step_hi;
        mid_r <= step_mid;
      end
      icdf_pkg::OP_CAP: begin
        neg_r    <= !cum_ge;
        diff_r   <= cum_ge ? ({1'b0, u_r} - rd_cum) : (rd_cum - {1'b0, u_r});
        energy_r <= rd_energy;
        slope_r  <= rd_slope;
      end
      icdf_pkg::OP_MULA: begin
        prod_lo_r <= icdf_pkg::PROD_W'(diff_r) *
                     icdf_pkg::PROD_W'(slope_r[icdf_pkg::SLOPE_LO_W-1:0]);
      end
      icdf_pkg::OP_MULB: begin
        prod_hi_r <= icdf_pkg::PROD_W'(diff_r) *
                     icdf_pkg::PROD_W'(slope_r[icdf_pkg::SLOPE_W-1:icdf_pkg::SLOPE_LO_W]);
      end
      icdf_pkg::OP_SUM: begin
        off_r <= full_prod[icdf_pkg::FULL_W-1:icdf_pkg::FRAC_W];
      end
      icdf_pkg::OP_EMIT: begin
        out_energy_r <= result;
        out_bin_r    <= icdf_pkg::INDEX_W'(lo_r);
      end
      default: begin
      end
    endcase
  end

  assign status.is_sample = (in_mode == icdf_pkg::MODE_SAMPLE);
  assign status.cum_ge    = cum_ge;
  assign status.bot_done  = bot_done;
  assign status.step_done = step_done;

  assign out_sampled_energy = out_energy_r;
  assign out_bin_found      = out_bin_r;

  // Every probe lies strictly inside the open search interval.
  a_mid_inside: assert property (@(posedge clk)
    cmd.op == icdf_pkg::OP_STEP |-> mid_r > lo_r && mid_r < hi_r)
    else $error("search probe outside the interval");

  // A fraction at or above the top point selects the last bin.
  a_top_bin: assert property (@(posedge clk)
    cmd.op == icdf_pkg::OP_TOP && cum_ge |=> hi_r - lo_r == AW'(1))
    else $error("top clamp did not select the last bin");

  // The chosen bin always lies below the upper bound of the interval.
  a_bin_order: assert property (@(posedge clk)
    cmd.op == icdf_pkg::OP_CAP |-> lo_r < hi_r)
    else $error("chosen bin not below the upper bound");

endmodule

@@ hdl/inverse_cdf_energy_sampler_unit.sv @@
// Top level of the inverse CDF energy sampler: configuration register and channel wiring.
//
// Usage: in_bus carries items with valid/ready. A load item (mode 0) writes one table
// point (energy, cumulative probability, slope) at point_index and returns nothing;
// indexes beyond the table are ignored. A sample item (mode 1) carries a random
// fraction and returns one item on out_bus: the interpolated energy and the bin index.
// The configuration port holds bin_count at byte address 0; write it only while idle.
// Timing: a load item is written into the table when it is accepted. A sample item
// whose fraction falls outside the table skips the binary search and shows its result
// sooner. The next item is accepted only after the result is registered, so the block
// takes no new item while a sample is in progress. The time per sample is set by the
// single read port of the table memory, probed once per cycle by the binary search,
// followed by the two-step split multiply, the partial product sum and the
// saturating add.
// Reset clears the controller and the result valid flag and sets bin_count to 2; the
// table contents are not cleared and must be loaded before sampling.
// When the receiver stalls, the result stays in the output register; a new sample may
// be accepted meanwhile but waits at its final step until the register is taken.
module inverse_cdf_energy_sampler_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  icdf_in_if.sink                       in_bus,
  icdf_out_if.source                    out_bus,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [icdf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [icdf_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [icdf_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic [icdf_pkg::COUNT_W-1:0] bin_count_r, bin_count_nxt;
  logic                         cfg_hit;
  icdf_pkg::dp_cmd_t            cmd;
  icdf_pkg::dp_status_t         status;

  // Register decode: one register, selected by the word address.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[icdf_pkg::CFG_AW-1:2] == icdf_pkg::CFG_IDX_BIN_COUNT);

  always_comb begin
    bin_count_nxt = bin_count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      bin_count_nxt = cfg_pwdata[icdf_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= icdf_pkg::BIN_COUNT_RESET;
    end else begin
      bin_count_r <= bin_count_nxt;
    end
  end

  // Read back of the register.
  assign cfg_prdata = cfg_hit ? icdf_pkg::CFG_DW'(bin_count_r) : '0;

  icdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd),
    .status    (status)
  );

  icdf_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .cmd                 (cmd),
    .status              (status),
    .bin_count           (bin_count_r),
    .in_mode             (in_bus.mode),
    .in_point_index      (in_bus.point_index),
    .in_point_energy     (in_bus.point_energy),
    .in_point_cumulative (in_bus.point_cumulative),
    .in_point_slope      (in_bus.point_slope),
    .in_random_fraction  (in_bus.random_fraction),
    .out_sampled_energy  (out_bus.sampled_energy),
    .out_bin_found       (out_bus.bin_found)
  );

endmodule

@@ verif/inverse_cdf_energy_sampler_checker.sv @@
// Checker that predicts the sampler's results from the observed traffic and compares them.
module inverse_cdf_energy_sampler_checker
  import icdf_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  icdf_in_if                in_bus,
  icdf_out_if               out_bus,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUM_W = OFF_W + 1;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [INDEX_W-1:0]  bin;
  } sample_answer_t;

  // Shadow copy of the spectrum table and of the point count register.
  logic [ENERGY_W-1:0] energy_mem [TABLE_DEPTH];
  logic [CUM_W-1:0]    cum_mem    [TABLE_DEPTH];
  logic [SLOPE_W-1:0]  slope_mem  [TABLE_DEPTH];
  logic [COUNT_W-1:0]  point_count;

  sample_answer_t awaited_samples [$];
  int             errors = 0;

  // Inverse transform of one random fraction over the current table.
  function automatic sample_answer_t interpolate_sample(logic [FRAC_W-1:0] frac);
    sample_answer_t      answer;
    logic [CUM_W-1:0]    u;
    logic [CUM_W-1:0]    base;
    logic [CUM_W-1:0]    delta;
    logic [FULL_W-1:0]   product;
    logic [OFF_W-1:0]    offset;
    logic [SUM_W-1:0]    total;
    int unsigned         n;
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         mid;
    int unsigned         bin;
    n = int'(point_count);
    if (n < MIN_POINTS) n = MIN_POINTS;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    u = CUM_W'(frac);
    // Clamp to the outer bins, otherwise halve [lo, hi) until one bin is left.
    if (u >= cum_mem[n-1]) begin
      bin = n - 2;
    end else if (u < cum_mem[0]) begin
      bin = 0;
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        if (u >= cum_mem[mid]) lo = mid;
        else hi = mid;
      end
      bin = lo;
    end
    // The offset is the truncated magnitude of the product and carries the sign of u - cum.
    base = cum_mem[bin];
    delta = (u >= base) ? u - base : base - u;
    product = FULL_W'(delta) * FULL_W'(slope_mem[bin]);
    offset = product[FULL_W-1:FRAC_W];
    if (u >= base) begin
      total = SUM_W'(energy_mem[bin]) + SUM_W'(offset);
      answer.energy = (total > SUM_W'({ENERGY_W{1'b1}})) ? '1 : total[ENERGY_W-1:0];
    end else begin
      answer.energy = (offset >= OFF_W'(energy_mem[bin])) ? '0 :
                      energy_mem[bin] - offset[ENERGY_W-1:0];
    end
    answer.bin = INDEX_W'(bin);
    return answer;
  endfunction

  // Results are checked before the same edge's input item is taken in.
  always @(posedge clk) begin : scoreboard
    sample_answer_t head;
    if (!rst_n) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        energy_mem[k] = '0;
        cum_mem[k] = '0;
        slope_mem[k] = '0;
      end
      point_count = BIN_COUNT_RESET;
      awaited_samples.delete();
    end else begin
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (awaited_samples.size() == 0) begin
          $error("result item with no sample waiting: sampled_energy %h, bin_found %0d",
                 out_bus.sampled_energy, out_bus.bin_found);
          errors++;
        end else begin
          head = awaited_samples.pop_front();
          if (out_bus.sampled_energy !== head.energy) begin
            $error("sampled_energy mismatch: expected %h, actual %h",
                   head.energy, out_bus.sampled_energy);
            errors++;
          end
          if (out_bus.bin_found !== head.bin) begin
            $error("bin_found mismatch: expected %0d, actual %0d",
                   head.bin, out_bus.bin_found);
            errors++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == CFG_IDX_BIN_COUNT) begin
        point_count = cfg_pwdata[COUNT_W-1:0];
      end
      // Load items update the table, sample items queue one expected result.
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
        if (in_bus.mode == MODE_SAMPLE) begin
          awaited_samples.insert(awaited_samples.size(),
                                 interpolate_sample(in_bus.random_fraction));
        end else if (int'(in_bus.point_index) < TABLE_DEPTH) begin
          energy_mem[in_bus.point_index] = in_bus.point_energy;
          cum_mem[in_bus.point_index] = in_bus.point_cumulative;
          slope_mem[in_bus.point_index] = in_bus.point_slope;
        end
      end
    end
    mismatch_count <= errors;
    results_pending <= awaited_samples.size();
  end

endmodule

@@ verif/inverse_cdf_energy_sampler_unit_tb.sv @@
// Testbench top of the inverse CDF energy sampler: clock, reset, stimulus and verdict.
module inverse_cdf_energy_sampler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icdf_pkg::*;

  localparam int TABLE_DEPTH   = 1024;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int ITEM_TARGET   = 1550;
  localparam int PHASES        = 10;
  localparam int MIN_PHASE     = 25;
  localparam int SMALL_TABLE   = 64;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [63:0] CUM_ONE = 64'h1_0000_0000;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int mismatch_total;
  int results_outstanding;
  int idle_cycles = 0;
  int items_sent;
  int send_calm;
  int active_points;

  // What the stimulus has loaded so far, used to aim fractions at bin edges.
  logic [63:0] loaded_cum    [TABLE_DEPTH];
  bit          point_written [TABLE_DEPTH];

  icdf_in_if  in_bus ();
  icdf_out_if out_bus ();

  inverse_cdf_energy_sampler_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  inverse_cdf_energy_sampler_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) sample_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_bus         (in_bus),
    .out_bus        (out_bus),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_total),
    .results_pending(results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Idle length for either side: mostly none or short, a few long, sometimes a calm stretch.
  function automatic int next_gap(inout int calm_left);
    int unsigned pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 4) begin
      calm_left = int'($urandom_range(20, 120));
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 85) return int'($urandom_range(1, 3));
    if (pick < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // Slopes of every magnitude, from zero up to the full 40 bits.
  function automatic logic [SLOPE_W-1:0] random_slope();
    logic [63:0] raw;
    int unsigned bits;
    raw = {$urandom, $urandom};
    bits = $urandom_range(SLOPE_W);
    return SLOPE_W'(raw & ((64'd1 << bits) - 64'd1));
  endfunction

  // Fractions: uniform, next to a loaded cumulative value, or at the ends of the range.
  function automatic logic [FRAC_W-1:0] pick_fraction(int n);
    int unsigned pick;
    int          k;
    longint      v;
    pick = $urandom_range(99);
    if (pick < 45) return $urandom;
    if (pick < 85) begin
      k = int'($urandom_range(n - 1));
      v = longint'(loaded_cum[k]) + longint'($urandom_range(2)) - 64'sd1;
      if (v < 0) v = 0;
      if (v > 64'sh0_FFFF_FFFF) v = 64'sh0_FFFF_FFFF;
      return FRAC_W'(v);
    end
    if (pick < 92) return '0;
    return '1;
  endfunction

  function automatic logic [COUNT_W-1:0] phase_setting(int phase);
    case (phase)
      0:       return COUNT_W'(2047);
      1:       return COUNT_W'(1024);
      2:       return COUNT_W'(0);
      3:       return COUNT_W'(1);
      4:       return COUNT_W'(3);
      5:       return COUNT_W'(7);
      6:       return COUNT_W'(16);
      7:       return COUNT_W'(5);
      8:       return COUNT_W'(33);
      default: return COUNT_W'(2);
    endcase
  endfunction

  // Present one item after a random gap and hold it until it is taken.
  task automatic drive_item(input logic mode, input logic [INDEX_W-1:0] idx,
                            input logic [ENERGY_W-1:0] energy,
                            input logic [CUM_W-1:0] cum, input logic [SLOPE_W-1:0] slope,
                            input logic [FRAC_W-1:0] frac);
    int gap;
    gap = next_gap(send_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode <= mode;
    in_bus.point_index <= idx;
    in_bus.point_energy <= energy;
    in_bus.point_cumulative <= cum;
    in_bus.point_slope <= slope;
    in_bus.random_fraction <= frac;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    items_sent++;
  endtask

  // Unused fields of each item carry random bits.
  task automatic load_point(input int idx, input logic [ENERGY_W-1:0] energy,
                            input logic [CUM_W-1:0] cum, input logic [SLOPE_W-1:0] slope);
    drive_item(MODE_LOAD, INDEX_W'(idx), energy, cum, slope, $urandom);
    loaded_cum[idx] = 64'(cum);
    point_written[idx] = 1'b1;
  endtask

  task automatic draw_sample(input logic [FRAC_W-1:0] frac);
    drive_item(MODE_SAMPLE, INDEX_W'($urandom), $urandom, CUM_W'({$urandom, $urandom}),
               SLOPE_W'({$urandom, $urandom}), frac);
  endtask

  // Hold the input back until every result has come and the block has settled.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_point_count(input logic [COUNT_W-1:0] value);
    wait_idle();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {CFG_IDX_BIN_COUNT, 2'b00};
    cfg_pwdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    active_points = (value < MIN_POINTS) ? MIN_POINTS :
                    (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
  endtask

  // Load points 0..n-1: mostly a proper spectrum, sometimes pure noise.
  task automatic build_table(input int n);
    bit          noisy;
    logic [63:0] step;
    logic [63:0] c;
    logic [63:0] e;
    noisy = ($urandom_range(99) < 15);
    step = CUM_ONE / 64'(n - 1);
    e = 64'($urandom_range(4095));
    c = '0;
    for (int k = 0; k < n; k++) begin
      if (noisy) begin
        load_point(k, $urandom, CUM_W'({$urandom, $urandom}), random_slope());
      end else begin
        // Cumulative values rise with jitter; some bins stay empty and the top may fall short.
        if (k == 0) begin
          c = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(32'(step / 2)));
        end else if (k == n - 1) begin
          c = ($urandom_range(3) == 0) ? CUM_ONE - 64'($urandom_range(1, 4096)) : CUM_ONE;
        end else if ($urandom_range(19) != 0) begin
          c = 64'(k) * step + 64'($urandom_range(32'(step / 2)));
        end
        e = e + 64'($urandom_range(32'(64'hFFFF_F000 / 64'(n))));
        load_point(k, ENERGY_W'(e), CUM_W'(c), random_slope());
      end
    end
  endtask

  // One item of the random part: mostly samples, the rest table rewrites and noise.
  task automatic random_item(input int n);
    int unsigned pick;
    int          k;
    pick = $urandom_range(99);
    k = int'($urandom_range(n - 1));
    if (pick < 65) begin
      draw_sample(pick_fraction(n));
    end else if (pick < 85) begin
      load_point(k, $urandom, CUM_W'(loaded_cum[k]), random_slope());
    end else if (pick < 93) begin
      load_point(int'($urandom_range(TABLE_DEPTH - 1)), $urandom,
                 CUM_W'({$urandom, $urandom}), SLOPE_W'({$urandom, $urandom}));
    end else begin
      load_point(k, $urandom, CUM_W'({$urandom, $urandom}), random_slope());
    end
  endtask

  // The result side stalls at random.
  initial begin : result_receiver
    int stall;
    int out_calm;
    stall = 0;
    out_calm = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
        stall = next_gap(out_calm);
      end
    end
  end

  // Any cycle without a handshake counts toward the hang limit.
  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int  n;
    int  budget;
    bit  complete;
    rst_n <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.mode <= MODE_LOAD;
    in_bus.point_index <= '0;
    in_bus.point_energy <= '0;
    in_bus.point_cumulative <= '0;
    in_bus.point_slope <= '0;
    in_bus.random_fraction <= '0;
    items_sent = 0;
    send_calm = 0;
    active_points = MIN_POINTS;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      point_written[k] = 1'b0;
      loaded_cum[k] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the two-point table that reset selects.
    load_point(0, 32'h0000_1000, 33'h0_4000_0000, 40'h00_0001_0000);
    load_point(1, 32'h0010_0000, 33'h1_0000_0000, 40'h00_0004_0000);
    // Below the table the offset is negative and saturates at zero.
    draw_sample(32'h0000_0000);
    draw_sample(32'h4000_0000);
    draw_sample(32'h4000_0001);
    draw_sample(32'hFFFF_FFFF);
    // Full slope on a high energy saturates at the top of the range.
    load_point(0, 32'hFFFF_FF00, 33'h0_0000_0000, 40'hFF_FFFF_FFFF);
    draw_sample(32'h8000_0000);
    // A falling table sends every fraction to the last bin.
    load_point(1, 32'h0000_0000, 33'h0_0000_0000, 40'h00_0000_0000);
    draw_sample(32'h1234_5678);
    load_point(0, 32'h0000_0000, 33'h1_FFFF_FFFF, 40'h00_0000_0000);
    draw_sample(32'hFFFF_FFFF);
    // Extreme field patterns at the far end of the table.
    load_point(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 40'hFF_FFFF_FFFF);
    load_point(TABLE_DEPTH / 2, 32'h0000_0000, 33'h0_0000_0000, 40'h00_0000_0000);
    load_point(0, 32'h0000_0100, 33'h0_0000_0000, 40'h00_0000_0100);
    load_point(1, 32'h0000_0200, 33'h1_0000_0000, 40'h00_0000_0100);
    draw_sample(32'h0000_0000);
    draw_sample(32'hFFFF_FFFF);

    // Random phases over several point counts, out-of-range settings included.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_point_count(phase_setting(phase));
      n = active_points;
      complete = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (!point_written[k]) complete = 1'b0;
      end
      if (n <= SMALL_TABLE || !complete) build_table(n);
      budget = (ITEM_TARGET - items_sent) / (PHASES - phase);
      if (budget < MIN_PHASE) budget = MIN_PHASE;
      repeat (budget) random_item(n);
    end

    wait_idle();
    if (mismatch_total == 0 && results_outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/icdf_pkg.sv
hdl/icdf_if.sv
hdl/icdf_ram.sv
hdl/icdf_ctrl.sv
hdl/icdf_dpath.sv
hdl/inverse_cdf_energy_sampler_unit.sv
verif/inverse_cdf_energy_sampler_checker.sv
verif/inverse_cdf_energy_sampler_unit_tb.sv
